FILE: hw/rtl/sips_pkg.sv
// Shared constants and types for the selectable in-place sorter.
package sips_pkg;

  localparam int COUNT_DEF      = 32;
  localparam int VALUE_BITS_DEF = 16;

  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;
  localparam int CMP_W    = 12;
  localparam int METHOD_W = 2;

  // sort_method register codes
  localparam logic [METHOD_W-1:0] METHOD_SELECT = 2'd0;
  localparam logic [METHOD_W-1:0] METHOD_BUBBLE = 2'd1;
  localparam logic [METHOD_W-1:0] METHOD_INSERT = 2'd2;

  typedef enum logic [1:0] {
    SORT_SELECT,
    SORT_BUBBLE,
    SORT_INSERT
  } sort_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_READ,
    S_CMP,
    S_SWRD,
    S_SWA,
    S_SWB,
    S_ORD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic out_valid;
    logic out_last;
  } status_t;

endpackage

FILE: hw/rtl/sips_store.sv
// Value store: one write port, two registered read ports.
module sips_store #(
  parameter int DEPTH = sips_pkg::COUNT_DEF,
  parameter int WIDTH = sips_pkg::VALUE_BITS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read two words, hold when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

FILE: hw/rtl/sips_seq.sv
// Sequencer: load, sort in place through the store, then stream the result.
module sips_seq #(
  parameter int COUNT      = sips_pkg::COUNT_DEF,
  parameter int VALUE_BITS = sips_pkg::VALUE_BITS_DEF,
  localparam int IDX_W     = (COUNT > 1) ? $clog2(COUNT) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_start,
  input  logic [VALUE_BITS-1:0]         in_word,
  input  logic [sips_pkg::METHOD_W-1:0] method,
  output sips_pkg::status_t             status,
  output logic [sips_pkg::CMP_W-1:0]    cmp_total,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [VALUE_BITS-1:0]         wr_data,
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr_a,
  output logic [IDX_W-1:0]              rd_addr_b,
  input  logic [VALUE_BITS-1:0]         rd_data_a,
  input  logic [VALUE_BITS-1:0]         rd_data_b
);

  localparam logic [IDX_W-1:0] ONE    = IDX_W'(1);
  localparam logic [IDX_W-1:0] TWO    = IDX_W'(2);
  localparam logic [IDX_W-1:0] LAST   = IDX_W'(COUNT - 1);
  localparam logic [IDX_W-1:0] PENULT = IDX_W'(COUNT - 2);
  localparam logic [IDX_W:0]   BUB_END = (IDX_W + 1)'(COUNT - 2);
  localparam logic [sips_pkg::CMP_W-1:0] CMP_ONE = sips_pkg::CMP_W'(1);

  sips_pkg::state_t state_r, state_nxt;
  sips_pkg::sort_t  method_r, method_nxt, method_dec;
  logic [IDX_W-1:0] load_cnt_r, load_cnt_nxt;
  logic [IDX_W-1:0] outer_r, outer_nxt;
  logic [IDX_W-1:0] inner_r, inner_nxt;
  logic [IDX_W-1:0] min_r, min_nxt;
  logic [IDX_W-1:0] sp_r, sp_nxt;
  logic [IDX_W-1:0] sq_r, sq_nxt;
  logic [sips_pkg::CMP_W-1:0] cmp_r, cmp_nxt;
  logic [IDX_W-1:0] min_sel;
  logic [IDX_W:0]   bub_sum;
  logic             next_step;
  logic             done;

  // decode the method register; the unused code falls back to selection
  always_comb begin
    unique case (method)
      sips_pkg::METHOD_BUBBLE: method_dec = sips_pkg::SORT_BUBBLE;
      sips_pkg::METHOD_INSERT: method_dec = sips_pkg::SORT_INSERT;
      default:                 method_dec = sips_pkg::SORT_SELECT;
    endcase
  end

  assign min_sel = (rd_data_a < rd_data_b) ? inner_r : min_r;
  assign bub_sum = {1'b0, inner_r} + {1'b0, outer_r};

  // state and index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sips_pkg::S_LOAD;
      method_r   <= sips_pkg::SORT_SELECT;
      load_cnt_r <= '0;
      outer_r    <= '0;
      inner_r    <= '0;
      min_r      <= '0;
      cmp_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      method_r   <= method_nxt;
      load_cnt_r <= load_cnt_nxt;
      outer_r    <= outer_nxt;
      inner_r    <= inner_nxt;
      min_r      <= min_nxt;
      cmp_r      <= cmp_nxt;
    end
  end

  // swap addresses
  always_ff @(posedge clk) begin
    sp_r <= sp_nxt;
    sq_r <= sq_nxt;
  end

  // next state and store access
  always_comb begin
    state_nxt    = state_r;
    method_nxt   = method_r;
    load_cnt_nxt = load_cnt_r;
    outer_nxt    = outer_r;
    inner_nxt    = inner_r;
    min_nxt      = min_r;
    sp_nxt       = sp_r;
    sq_nxt       = sq_r;
    cmp_nxt      = cmp_r;
    wr_en        = 1'b0;
    wr_addr      = load_cnt_r;
    wr_data      = in_word;
    rd_en        = 1'b0;
    rd_addr_a    = inner_r;
    rd_addr_b    = min_r;
    next_step    = 1'b0;
    done         = 1'b0;

    unique case (state_r)
      sips_pkg::S_LOAD: begin
        if (in_start) begin
          wr_en = 1'b1;
          if (load_cnt_r == LAST) begin
            load_cnt_nxt = '0;
            method_nxt   = method_dec;
            cmp_nxt      = '0;
            state_nxt    = sips_pkg::S_READ;
            unique case (method_dec)
              sips_pkg::SORT_BUBBLE: begin
                outer_nxt = '0;
                inner_nxt = '0;
              end
              sips_pkg::SORT_INSERT: begin
                outer_nxt = ONE;
                inner_nxt = ONE;
              end
              default: begin
                outer_nxt = '0;
                min_nxt   = '0;
                inner_nxt = ONE;
              end
            endcase
          end else begin
            load_cnt_nxt = load_cnt_r + ONE;
          end
        end
      end

      sips_pkg::S_READ: begin
        rd_en = 1'b1;
        unique case (method_r)
          sips_pkg::SORT_BUBBLE: begin
            rd_addr_a = inner_r;
            rd_addr_b = inner_r + ONE;
          end
          sips_pkg::SORT_INSERT: begin
            rd_addr_a = inner_r - ONE;
            rd_addr_b = inner_r;
          end
          default: begin
            rd_addr_a = inner_r;
            rd_addr_b = min_r;
          end
        endcase
        state_nxt = sips_pkg::S_CMP;
      end

      sips_pkg::S_CMP: begin
        cmp_nxt = cmp_r + CMP_ONE;
        unique case (method_r)
          sips_pkg::SORT_BUBBLE: begin
            if (rd_data_a > rd_data_b) begin
              sp_nxt    = inner_r;
              sq_nxt    = inner_r + ONE;
              state_nxt = sips_pkg::S_SWA;
            end else begin
              next_step = 1'b1;
            end
          end
          sips_pkg::SORT_INSERT: begin
            if (rd_data_a > rd_data_b) begin
              sp_nxt    = inner_r - ONE;
              sq_nxt    = inner_r;
              state_nxt = sips_pkg::S_SWA;
            end else begin
              next_step = 1'b1;
            end
          end
          default: begin
            min_nxt = min_sel;
            if (inner_r == LAST) begin
              if (min_sel != outer_r) begin
                sp_nxt    = outer_r;
                sq_nxt    = min_sel;
                state_nxt = sips_pkg::S_SWRD;
              end else begin
                next_step = 1'b1;
              end
            end else begin
              inner_nxt = inner_r + ONE;
              state_nxt = sips_pkg::S_READ;
            end
          end
        endcase
      end

      sips_pkg::S_SWRD: begin
        rd_en     = 1'b1;
        rd_addr_a = sp_r;
        rd_addr_b = sq_r;
        state_nxt = sips_pkg::S_SWA;
      end

      sips_pkg::S_SWA: begin
        wr_en     = 1'b1;
        wr_addr   = sp_r;
        wr_data   = rd_data_b;
        state_nxt = sips_pkg::S_SWB;
      end

      sips_pkg::S_SWB: begin
        wr_en   = 1'b1;
        wr_addr = sq_r;
        wr_data = rd_data_a;
        unique case (method_r)
          sips_pkg::SORT_INSERT: begin
            // moving into the front position: the bound check still counts
            if (inner_r == ONE) begin
              cmp_nxt   = cmp_r + CMP_ONE;
              next_step = 1'b1;
            end else begin
              inner_nxt = inner_r - ONE;
              state_nxt = sips_pkg::S_READ;
            end
          end
          default: next_step = 1'b1;
        endcase
      end

      sips_pkg::S_ORD: begin
        rd_en     = 1'b1;
        rd_addr_a = inner_r;
        state_nxt = sips_pkg::S_OUT;
      end

      sips_pkg::S_OUT: begin
        if (inner_r == LAST) begin
          state_nxt = sips_pkg::S_LOAD;
        end else begin
          inner_nxt = inner_r + ONE;
          rd_en     = 1'b1;
          rd_addr_a = inner_r + ONE;
        end
      end

      default: state_nxt = sips_pkg::S_LOAD;
    endcase

    // advance the loop indices after a finished compare step
    if (next_step) begin
      unique case (method_r)
        sips_pkg::SORT_BUBBLE: begin
          if (bub_sum == BUB_END) begin
            if (outer_r == PENULT) begin
              done = 1'b1;
            end else begin
              outer_nxt = outer_r + ONE;
              inner_nxt = '0;
              state_nxt = sips_pkg::S_READ;
            end
          end else begin
            inner_nxt = inner_r + ONE;
            state_nxt = sips_pkg::S_READ;
          end
        end
        sips_pkg::SORT_INSERT: begin
          if (outer_r == LAST) begin
            done = 1'b1;
          end else begin
            outer_nxt = outer_r + ONE;
            inner_nxt = outer_r + ONE;
            state_nxt = sips_pkg::S_READ;
          end
        end
        default: begin
          if (outer_r == PENULT) begin
            done = 1'b1;
          end else begin
            outer_nxt = outer_r + ONE;
            min_nxt   = outer_r + ONE;
            inner_nxt = outer_r + TWO;
            state_nxt = sips_pkg::S_READ;
          end
        end
      endcase
    end

    // start the output burst
    if (done) begin
      inner_nxt = '0;
      state_nxt = sips_pkg::S_ORD;
    end
  end

  assign status.busy      = (state_r != sips_pkg::S_LOAD);
  assign status.out_valid = (state_r == sips_pkg::S_OUT);
  assign status.out_last  = (inner_r == LAST);
  assign cmp_total        = cmp_r;

endmodule

FILE: hw/rtl/selectable_in_place_sorter_core.sv
// Top level: loads COUNT words, sorts them in place, streams them out ascending.
// Loading writes one word per cycle while start is high. A compare step reads a pair (S_READ) and
// compares it (S_CMP); a swap writes both words back (S_SWA, S_SWB), selection sort first
// rereading them (S_SWRD), all set by the single store write port. Output: after the sort,
// a read state (S_ORD), then COUNT words back to back, never stalled; busy blocks new loads.
// Reset clears counters, method and control; store contents stay undefined.
module selectable_in_place_sorter_core #(
  parameter int COUNT      = sips_pkg::COUNT_DEF,
  parameter int VALUE_BITS = sips_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sips_pkg::IN_W-1:0]     in_load_value,
  output logic                          out_valid,
  output logic [sips_pkg::OUT_W-1:0]    out_sorted_value,
  output logic                          out_final_item,
  output logic [sips_pkg::CMP_W-1:0]    out_comparison_total,
  input  logic                          cfg_wr_en,
  input  logic [sips_pkg::METHOD_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (COUNT > 1) ? $clog2(COUNT) : 1;

  logic [sips_pkg::METHOD_W-1:0] method_r;
  logic [VALUE_BITS-1:0] load_word;
  sips_pkg::status_t     status;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr_a;
  logic [IDX_W-1:0]      rd_addr_b;
  logic [VALUE_BITS-1:0] rd_data_a;
  logic [VALUE_BITS-1:0] rd_data_b;

  // hold the sort method register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= sips_pkg::METHOD_SELECT;
    end else if (cfg_wr_en) begin
      method_r <= cfg_wr_data;
    end
  end

  // fit the input word to the store width
  always_comb begin
    load_word = '0;
    for (int i = 0; i < VALUE_BITS && i < sips_pkg::IN_W; i++) begin
      load_word[i] = in_load_value[i];
    end
  end

  // fit the store word to the output width
  always_comb begin
    out_sorted_value = '0;
    for (int i = 0; i < VALUE_BITS && i < sips_pkg::OUT_W; i++) begin
      out_sorted_value[i] = rd_data_a[i];
    end
  end

  sips_seq #(
    .COUNT      (COUNT),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_start  (start),
    .in_word   (load_word),
    .method    (method_r),
    .status    (status),
    .cmp_total (out_comparison_total),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  sips_store #(
    .DEPTH (COUNT),
    .WIDTH (VALUE_BITS)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign busy           = status.busy;
  assign out_valid      = status.out_valid;
  assign out_final_item = status.out_valid & status.out_last;

endmodule
